/* sv/uvn_pkg.sv */
// Package: widths, item types and pipeline stage type for the unit vector block.
`timescale 1ns / 1ps
`default_nettype none
package uvn_pkg;

    localparam int IN_WIDTH  = 32;
    localparam int FRAC_BITS = 30;
    localparam int OUT_W     = 32;

    localparam int SQ_W   = 2 * IN_WIDTH;             // square of a magnitude
    localparam int SUM_W  = 2 * IN_WIDTH;             // x^2 + y^2
    localparam int R_W    = FRAC_BITS + 1;            // result magnitude, up to 2^FRAC_BITS
    localparam int Q_W    = R_W + SUM_W;              // r * sum
    localparam int DW     = 2 * FRAC_BITS + SUM_W + 2; // residual and increments
    localparam int N_BITS = FRAC_BITS + 1;            // search steps
    localparam int N_ST   = N_BITS + 1;               // init stage plus search stages

    localparam int Q_DEPTH = 4;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    typedef logic [DW-1:0] dw_t;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] x_comp;
        logic signed [IN_WIDTH-1:0] y_comp;
    } vec_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] unit_x;
        logic signed [OUT_W-1:0] unit_y;
        logic                    invalid;
    } res_t;

    typedef struct packed {
        logic [SQ_W-1:0] x2;
        logic [SQ_W-1:0] y2;
        logic            neg_x;
        logic            neg_y;
    } sq_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
        dw_t              dx;
        logic [Q_W-1:0]   qx;
        logic [R_W-1:0]   rx;
        dw_t              dy;
        logic [Q_W-1:0]   qy;
        logic [R_W-1:0]   ry;
    } stage_t;

endpackage
`default_nettype wire

/* sv/uvn_front.sv */
// Front end: accept a vector, take component magnitudes and squares.
`timescale 1ns / 1ps
`default_nettype none
module uvn_front
    import uvn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire vec_t vec,
    output logic      sq_valid,
    input  wire logic sq_ready,
    output sq_t       sq
);

    logic                valid_reg;
    logic                valid_next;
    sq_t                 sq_reg;
    sq_t                 sq_next;
    logic                adv;
    logic [IN_WIDTH-1:0] mag_x;
    logic [IN_WIDTH-1:0] mag_y;

    // Advance when the register is empty or its item moves on.
    assign adv  = !valid_reg || sq_ready;
    assign full = !adv;

    always_comb
    begin
        mag_x = vec.x_comp[IN_WIDTH-1] ? (~vec.x_comp + 1'b1) : vec.x_comp;
        mag_y = vec.y_comp[IN_WIDTH-1] ? (~vec.y_comp + 1'b1) : vec.y_comp;
        sq_next.x2    = SQ_W'(mag_x) * SQ_W'(mag_x);
        sq_next.y2    = SQ_W'(mag_y) * SQ_W'(mag_y);
        sq_next.neg_x = vec.x_comp[IN_WIDTH-1];
        sq_next.neg_y = vec.y_comp[IN_WIDTH-1];
        valid_next    = adv ? push : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && push)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq_valid = valid_reg;
    assign sq       = sq_reg;

endmodule
`default_nettype wire

/* sv/uvn_queue.sv */
// Short queue between the front end and the search pipeline.
`timescale 1ns / 1ps
`default_nettype none
module uvn_queue
    import uvn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire sq_t  wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output sq_t       rd_data
);

    sq_t             mem_reg [Q_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg;
    logic [QA_W-1:0] wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg;
    logic [QA_W-1:0] rd_ptr_next;
    logic [QC_W-1:0] cnt_reg;
    logic [QC_W-1:0] cnt_next;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = (cnt_reg != QC_W'(Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? QA_W'((QC_W'(wr_ptr_reg) + 1'b1) % Q_DEPTH) : wr_ptr_reg;
        rd_ptr_next = do_rd ? QA_W'((QC_W'(rd_ptr_reg) + 1'b1) % Q_DEPTH) : rd_ptr_reg;
        cnt_next    = cnt_reg + QC_W'(do_wr) - QC_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

/* sv/uvn_back.sv */
// Back end: bit-by-bit search of each unit component, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module uvn_back
    import uvn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic sq_valid,
    output logic      sq_ready,
    input  wire sq_t  sq,
    output logic      empty,
    input  wire logic pop,
    output res_t      res
);

    logic   valid_reg [N_ST];
    stage_t stage_reg [N_ST];
    stage_t stage_next [N_ST];
    logic   out_valid_reg;
    res_t   out_reg;
    res_t   out_next;
    logic   adv;
    logic [SUM_W-1:0] sum_w;

    // Whole pipeline moves together; it stalls only while a result waits.
    assign adv      = !out_valid_reg || pop;
    assign sq_ready = adv;
    assign empty    = !out_valid_reg;
    assign res      = out_reg;

    // Init stage: sum of squares, residual targets c^2 * 2^(2F).
    always_comb
    begin
        sum_w               = SUM_W'(sq.x2) + SUM_W'(sq.y2);
        stage_next[0].sum   = sum_w;
        stage_next[0].neg_x = sq.neg_x;
        stage_next[0].neg_y = sq.neg_y;
        stage_next[0].zero  = (sum_w == '0);
        stage_next[0].dx    = dw_t'(sq.x2) << (2 * FRAC_BITS);
        stage_next[0].qx    = '0;
        stage_next[0].rx    = '0;
        stage_next[0].dy    = dw_t'(sq.y2) << (2 * FRAC_BITS);
        stage_next[0].qy    = '0;
        stage_next[0].ry    = '0;
    end

    // Stage i decides bit K = FRAC_BITS - i. With P = r^2*S kept as the
    // residual D = T - P and Q = r*S, trying bit K costs Q<<(K+1) + S<<2K.
    for (genvar i = 0; i < N_BITS; i++)
    begin : g_bit
        localparam int K = FRAC_BITS - i;
        dw_t       inc_x;
        dw_t       inc_y;
        logic [DW:0] dif_x;
        logic [DW:0] dif_y;

        always_comb
        begin
            inc_x = (dw_t'(stage_reg[i].qx) << (K + 1)) + (dw_t'(stage_reg[i].sum) << (2 * K));
            inc_y = (dw_t'(stage_reg[i].qy) << (K + 1)) + (dw_t'(stage_reg[i].sum) << (2 * K));
            dif_x = {1'b0, stage_reg[i].dx} - {1'b0, inc_x};
            dif_y = {1'b0, stage_reg[i].dy} - {1'b0, inc_y};
            stage_next[i+1] = stage_reg[i];
            if (!dif_x[DW])
            begin
                stage_next[i+1].dx = dif_x[DW-1:0];
                stage_next[i+1].qx = stage_reg[i].qx + (Q_W'(stage_reg[i].sum) << K);
                stage_next[i+1].rx = stage_reg[i].rx | (R_W'(1) << K);
            end
            if (!dif_y[DW])
            begin
                stage_next[i+1].dy = dif_y[DW-1:0];
                stage_next[i+1].qy = stage_reg[i].qy + (Q_W'(stage_reg[i].sum) << K);
                stage_next[i+1].ry = stage_reg[i].ry | (R_W'(1) << K);
            end
        end
    end

    // Apply signs; drop magnitudes for the zero vector.
    always_comb
    begin
        out_next.invalid = stage_reg[N_ST-1].zero;
        out_next.unit_x  = stage_reg[N_ST-1].neg_x ? -OUT_W'(stage_reg[N_ST-1].rx)
                                                   : OUT_W'(stage_reg[N_ST-1].rx);
        out_next.unit_y  = stage_reg[N_ST-1].neg_y ? -OUT_W'(stage_reg[N_ST-1].ry)
                                                   : OUT_W'(stage_reg[N_ST-1].ry);
        if (stage_reg[N_ST-1].zero)
        begin
            out_next.unit_x = '0;
            out_next.unit_y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < N_ST; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= sq_valid;
            for (int j = 1; j < N_ST; j++)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
            out_valid_reg <= valid_reg[N_ST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg[0] <= stage_next[0];
            for (int j = 1; j < N_ST; j++)
            begin
                stage_reg[j] <= stage_next[j];
            end
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

/* sv/unit_vector_normalize_2d.sv */
// Top level: 2D unit vector in signed Q1.30 from signed integer components.
`timescale 1ns / 1ps
`default_nettype none
// Takes a vector (x, y) and returns x*2^30/sqrt(x^2+y^2) and the same for y,
// each truncated toward zero, so +/-2^30 stands for +/-1.0. The zero vector
// gives invalid high with both components zero. One item a cycle enters and
// one result a cycle leaves when neither side stalls. From push to result
// an item passes the register that squares the magnitudes, the four-entry
// queue, the stage that forms the sum of squares, one stage per result bit
// (31 stages of shift, add and compare that build each magnitude without
// any multiply), and the result register. The search pipeline stalls as a
// whole only while a result waits to be popped; the queue lets the front
// keep taking items meanwhile, until it fills.
module unit_vector_normalize_2d
    import uvn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire vec_t vec,
    output logic      empty,
    input  wire logic pop,
    output res_t      res
);

    logic f_valid;
    logic f_ready;
    sq_t  f_sq;
    logic b_valid;
    logic b_ready;
    sq_t  b_sq;

    // Classify: sign and square of each component.
    uvn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .vec      (vec),
        .sq_valid (f_valid),
        .sq_ready (f_ready),
        .sq       (f_sq)
    );

    // Decouple front and back.
    uvn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_sq),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_sq)
    );

    // Search each unit component one bit per stage.
    uvn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .sq_valid (b_valid),
        .sq_ready (b_ready),
        .sq       (b_sq),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

endmodule
`default_nettype wire

/* sv/uvn_checker.sv */
// Port-level checks for the unit vector block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module uvn_checker
    import uvn_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire logic full,
    input wire vec_t vec,
    input wire logic empty,
    input wire logic pop,
    input wire res_t res
);

    localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << FRAC_BITS;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(res))
        else $error("waiting result changed");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && res.invalid |-> res.unit_x == '0 && res.unit_y == '0)
        else $error("invalid result with nonzero component");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !res.invalid |-> res.unit_x != '0 || res.unit_y != '0)
        else $error("valid result with both components zero");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> res.unit_x <= ONE && res.unit_x >= -ONE
                && res.unit_y <= ONE && res.unit_y >= -ONE)
        else $error("component beyond unit range");

endmodule

bind unit_vector_normalize_2d uvn_checker u_chk (.*);
`default_nettype wire

/* dv/tb_top.sv */
// Testbench for the 2D unit vector block: queued stimulus, exact predictor, in-order checks.
`timescale 1ns / 1ps
module tb_top;
    import uvn_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    vec_t vec = '0;
    res_t res;

    // Stimulus feeds the driver through this queue; the predictor fills expected_units.
    vec_t pending_vecs[$];
    res_t expected_units[$];
    int   error_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_pop = 1'b0;
    bit   in_acc = 1'b0;

    unit_vector_normalize_2d u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .vec   (vec),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

    always #5 clk = ~clk;

    // Largest r with r^2 * sum <= c2 * 2^(2*FRAC_BITS), one bit at a time from the top.
    function automatic logic [R_W-1:0] unit_magnitude(logic [127:0] c2, logic [127:0] sum);
        logic [127:0] target;
        logic [127:0] cand;
        logic [R_W-1:0] r;
        target = c2 << (2 * FRAC_BITS);
        r = '0;
        for (int b = FRAC_BITS; b >= 0; b--)
        begin
            cand = 128'(r) | (128'd1 << b);
            if (cand * cand * sum <= target)
                r = cand[R_W-1:0];
        end
        return r;
    endfunction

    // Predict the unit vector of one item; the zero vector flags invalid.
    function automatic res_t normalize_vec(vec_t v);
        res_t o;
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] sum;
        logic signed [OUT_W-1:0] mx;
        logic signed [OUT_W-1:0] my;
        ax = v.x_comp[IN_WIDTH-1] ? 128'(-65'(signed'(v.x_comp))) : 128'(v.x_comp);
        ay = v.y_comp[IN_WIDTH-1] ? 128'(-65'(signed'(v.y_comp))) : 128'(v.y_comp);
        sum = ax * ax + ay * ay;
        o = '0;
        if (sum == 0)
        begin
            o.invalid = 1'b1;
            return o;
        end
        mx = OUT_W'(unit_magnitude(ax * ax, sum));
        my = OUT_W'(unit_magnitude(ay * ay, sum));
        o.unit_x = v.x_comp[IN_WIDTH-1] ? -mx : mx;
        o.unit_y = v.y_comp[IN_WIDTH-1] ? -my : my;
        return o;
    endfunction

    function automatic logic [IN_WIDTH-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return IN_WIDTH'($urandom_range(0, 7)) - 3;
            1: return IN_WIDTH'({1'b1, IN_WIDTH'(0)} >> ($urandom_range(1, IN_WIDTH)));
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return IN_WIDTH'($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // Driver: offer items at the falling edge; hold the item until accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_acc)
                void'(pending_vecs.pop_front());
            if (push && !in_acc)
                push <= 1'b1;
            else if (pending_vecs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                push <= 1'b1;
                vec  <= pending_vecs[0];
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: randomly stall pop, or hold off entirely during the backpressure phase.
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= !hold_pop && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict at acceptance; check results against the oldest expectation.
    always @(posedge clk)
    begin
        in_acc = rst_n && push && !full;
        if (in_acc)
            expected_units.push_back(normalize_vec(vec));
        if (rst_n && pop && !empty)
        begin
            if (expected_units.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, res);
                error_count++;
            end
            else
            begin
                if (res.unit_x !== expected_units[0].unit_x)
                begin
                    $display("%0t: unit_x expected %0d actual %0d", $time,
                             expected_units[0].unit_x, res.unit_x);
                    error_count++;
                end
                if (res.unit_y !== expected_units[0].unit_y)
                begin
                    $display("%0t: unit_y expected %0d actual %0d", $time,
                             expected_units[0].unit_y, res.unit_y);
                    error_count++;
                end
                if (res.invalid !== expected_units[0].invalid)
                begin
                    $display("%0t: invalid expected %0b actual %0b", $time,
                             expected_units[0].invalid, res.invalid);
                    error_count++;
                end
                void'(expected_units.pop_front());
            end
        end
    end

    task automatic add_vec(logic [IN_WIDTH-1:0] x, logic [IN_WIDTH-1:0] y);
        vec_t v;
        v.x_comp = x;
        v.y_comp = y;
        pending_vecs.push_back(v);
    endtask

    // Wait until the driver has drained the queue and every result has come.
    task automatic drain_all();
        while (pending_vecs.size() > 0 || push || expected_units.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero vector, axes, extremes, diagonals, mixed signs.
        add_vec(0, 0);
        add_vec(1, 0);
        add_vec(0, -1);
        add_vec(32'h8000_0000, 0);
        add_vec(0, 32'h8000_0000);
        add_vec(32'h7FFF_FFFF, 0);
        add_vec(32'h8000_0000, 32'h8000_0000);
        add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_vec(32'h8000_0000, 32'h7FFF_FFFF);
        add_vec(32'h7FFF_FFFF, 32'h8000_0000);
        add_vec(1, 1);
        add_vec(-1, -1);
        add_vec(3, -4);
        add_vec(-5, 12);
        add_vec(1, 32'h7FFF_FFFF);
        add_vec(32'h8000_0000, -1);
        add_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_vec(32'h5555_5555, 32'hAAAA_AAAA);
        drain_all();

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 32;
        recv_idle_pct = 74;
        for (int i = 0; i < 170; i++)
            add_vec(rand_comp(), rand_comp());
        drain_all();

        // Receiver holds off a long stretch while the sender keeps offering items.
        send_idle_pct = 0;
        hold_pop = 1'b1;
        for (int i = 0; i < 40; i++)
            add_vec(rand_comp(), rand_comp());
        repeat (200) @(posedge clk);
        hold_pop = 1'b0;
        drain_all();

        send_idle_pct = 74;
        recv_idle_pct = 32;
        for (int i = 0; i < 170; i++)
            add_vec(rand_comp(), rand_comp());
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 170; i++)
            add_vec(rand_comp(), rand_comp());
        drain_all();

        // Let any stray late result show up before the verdict.
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
